[rtl/ftsu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftsu_pkg
// shared types and codes of the frame-time sync unit
// ----------------------------------------------------------------------------
package ftsu_pkg;

  // item kinds
  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_STROBE    = 3'd1,
    KIND_ENABLE    = 3'd2,
    KIND_DISABLE   = 3'd3,
    KIND_PARTNER   = 3'd4,
    KIND_READ_TIME = 3'd5,
    KIND_READ_LAST = 3'd6,
    KIND_READ_STAT = 3'd7
  } kind_e;

  // sync modes
  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_SYNCING  = 2'd1,
    MODE_ACTIVE   = 2'd2
  } mode_e;

  // result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_ACTIVE = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_STROBES_EXPECTED = 3'd0;
  localparam logic [2:0] REG_STROBE_DELAY_NS  = 3'd1;
  localparam logic [2:0] REG_REF_PER_TICK     = 3'd2;
  localparam logic [2:0] REG_NS_PER_REF       = 3'd3;
  localparam logic [2:0] REG_SEED_FRAME_TIME  = 3'd4;

  // register reset values
  localparam logic [2:0]  RST_STROBES_EXPECTED = 3'd1;
  localparam logic [23:0] RST_STROBE_DELAY_NS  = 24'd1000000;
  localparam logic [32:0] RST_REF_PER_TICK     = 33'd1717986918;
  localparam logic [45:0] RST_NS_PER_REF       = 46'd3413333;
  localparam logic [63:0] RST_SEED_FRAME_TIME  = 64'd0;

  // pairing sequencer states
  typedef enum logic [7:0] {
    SEQ_IDLE = 8'b0000_0001,
    SEQ_RD0  = 8'b0000_0010,
    SEQ_RD1  = 8'b0000_0100,
    SEQ_MUL  = 8'b0000_1000,
    SEQ_SUM  = 8'b0001_0000,
    SEQ_ERR  = 8'b0010_0000,
    SEQ_UPD  = 8'b0100_0000,
    SEQ_DONE = 8'b1000_0000
  } seq_state_e;

endpackage
`default_nettype wire

[rtl/ftsu_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftsu_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ftsu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/frame_time_sync_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frame_time_sync_unit
// frame-time keeper with strobe capture and partner time alignment
// ----------------------------------------------------------------------------
// path: stage 1, stage 2, then the result register, each held while the next is stalled
// throughput: one item per cycle while the output does not stall, except a partner time
//   item taken while syncing; that one waits for the two pipeline stages to drain, then
//   holds the input while the pairing unit runs its update alone (no pair) or its table
//   reads, split 64x46 interval multiply, sum, error and update steps (pair)
// reset: mode inactive, counter stopped and cleared, registers to defaults; table not cleared
module frame_time_sync_unit #(
  parameter int MAX_STROBES = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [63:0] partner_time_i,
  input  wire logic        is_last_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      time_value_o,
  output logic [1:0]       status_o,
  output logic [1:0]       sync_mode_o,
  output logic [31:0]      strobes_received_o
);

  localparam int CW = $clog2(MAX_STROBES + 1);  // capture count, holds MAX_STROBES
  localparam int AW = $clog2(MAX_STROBES);      // table address

  // configuration registers
  logic [2:0]  exp_q;
  logic [23:0] delay_q;
  logic [32:0] ratio_q;
  logic [45:0] nspr_q;
  logic [63:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= ftsu_pkg::RST_STROBES_EXPECTED;
      delay_q <= ftsu_pkg::RST_STROBE_DELAY_NS;
      ratio_q <= ftsu_pkg::RST_REF_PER_TICK;
      nspr_q  <= ftsu_pkg::RST_NS_PER_REF;
      seed_q  <= ftsu_pkg::RST_SEED_FRAME_TIME;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ftsu_pkg::REG_STROBES_EXPECTED: exp_q   <= cfg_data_i[2:0];
        ftsu_pkg::REG_STROBE_DELAY_NS:  delay_q <= cfg_data_i[23:0];
        ftsu_pkg::REG_REF_PER_TICK:     ratio_q <= cfg_data_i[32:0];
        ftsu_pkg::REG_NS_PER_REF:       nspr_q  <= cfg_data_i[45:0];
        ftsu_pkg::REG_SEED_FRAME_TIME:  seed_q  <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // front state: updated at the input transfer
  // --------------------------------------------------------------------------
  ftsu_pkg::mode_e mode_q, mode_d;
  logic [31:0]     cnt_q, cnt_d;
  logic            run_q, run_d;
  logic [63:0]     base_q, base_d;
  logic [CW-1:0]   cap_idx_q, cap_idx_d;
  logic [CW-1:0]   pair_q, pair_d;
  logic [31:0]     total_q, total_d;

  // pairing state: written by the pairing unit, cleared by enable
  logic [63:0]     least_q, least_d;
  logic            have_q, have_d;
  logic [63:0]     corr_q, corr_d;
  logic            down_q, down_d;
  logic [63:0]     last_ev_q;

  ftsu_pkg::seq_state_e seq_q;

  // pipeline control
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_free, mv2, mv1, seq_busy, partner_sync, in_accept;

  assign seq_busy     = (seq_q != ftsu_pkg::SEQ_IDLE);
  assign partner_sync = (kind_i == ftsu_pkg::KIND_PARTNER) &&
                        (mode_q == ftsu_pkg::MODE_SYNCING);
  assign out_free     = !out_v_q || !out_stall_i;
  assign mv2          = s2_v_q && out_free;
  assign mv1          = s1_v_q && (!s2_v_q || mv2);
  // a partner item while syncing runs alone so that it sees every capture
  assign in_stall_o   = seq_busy || (s1_v_q && !mv1) ||
                        (partner_sync && (s1_v_q || s2_v_q));
  assign in_accept    = in_valid_i && !in_stall_o;

  // front decode
  logic [31:0]   snap_cnt;
  logic          do_cap, do_lev, rd_time, rd_last, seq_go, take;
  logic [1:0]    st;
  logic [31:0]   total_inc;
  logic [63:0]   base_corr;

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    run_d     = run_q;
    base_d    = base_q;
    cap_idx_d = cap_idx_q;
    pair_d    = pair_q;
    total_d   = total_q;
    snap_cnt  = cnt_q;
    do_cap    = 1'b0;
    do_lev    = 1'b0;
    rd_time   = 1'b0;
    rd_last   = 1'b0;
    seq_go    = 1'b0;
    take      = 1'b0;
    st        = ftsu_pkg::STATUS_OK;
    total_inc = (total_q != '1) ? total_q + 32'd1 : total_q;
    base_corr = down_q ? base_q - corr_q : base_q + corr_q;
    if (in_accept) begin
      unique case (ftsu_pkg::kind_e'(kind_i))
        ftsu_pkg::KIND_TICK: begin
          if (run_q) begin
            cnt_d = cnt_q + 32'd1;
            // counter wrap carries one ratio into the base
            if (cnt_q == '1) begin
              base_d = base_q + 64'(ratio_q);
            end
          end
        end
        ftsu_pkg::KIND_STROBE: begin
          if (mode_q == ftsu_pkg::MODE_SYNCING) begin
            if (32'(cap_idx_q) < 32'(MAX_STROBES)) begin
              // first capture starts the local counter from zero
              if (cap_idx_q == '0) begin
                cnt_d    = '0;
                run_d    = 1'b1;
                snap_cnt = '0;
              end
              do_cap    = 1'b1;
              cap_idx_d = cap_idx_q + CW'(1);
            end
            total_d = total_inc;
          end else if (mode_q == ftsu_pkg::MODE_ACTIVE) begin
            do_lev  = 1'b1;
            total_d = total_inc;
          end
        end
        ftsu_pkg::KIND_ENABLE: begin
          cnt_d     = '0;
          run_d     = 1'b0;
          base_d    = seed_q;
          cap_idx_d = '0;
          pair_d    = '0;
          total_d   = '0;
          mode_d    = ftsu_pkg::MODE_SYNCING;
        end
        ftsu_pkg::KIND_DISABLE: begin
          run_d  = 1'b0;
          mode_d = ftsu_pkg::MODE_INACTIVE;
        end
        ftsu_pkg::KIND_PARTNER: begin
          if (mode_q == ftsu_pkg::MODE_SYNCING) begin
            seq_go = 1'b1;
            if (32'(cap_idx_q) != 32'(exp_q)) begin
              // capture count disagrees with the expected strobe count: restart pairing
              pair_d = '0;
              st     = ftsu_pkg::STATUS_MISMATCH;
            end else begin
              take = (pair_q != '0) && (32'(pair_q) < 32'(MAX_STROBES)) &&
                     (32'(pair_q) < 32'(exp_q));
              if (32'(pair_q) < 32'(MAX_STROBES)) begin
                pair_d = pair_q + CW'(1);
              end
              if (is_last_i) begin
                mode_d = ftsu_pkg::MODE_ACTIVE;
                pair_d = '0;
              end
            end
          end
        end
        ftsu_pkg::KIND_READ_TIME: rd_time = 1'b1;
        ftsu_pkg::KIND_READ_LAST: begin
          if (mode_q == ftsu_pkg::MODE_ACTIVE) begin
            rd_last = 1'b1;
          end else begin
            st = ftsu_pkg::STATUS_NOT_ACTIVE;
          end
        end
        default: ;  // status read: no state change
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ftsu_pkg::MODE_INACTIVE;
      cnt_q     <= '0;
      run_q     <= 1'b0;
      base_q    <= '0;
      cap_idx_q <= '0;
      pair_q    <= '0;
      total_q   <= '0;
    end else begin
      mode_q    <= mode_d;
      cnt_q     <= cnt_d;
      run_q     <= run_d;
      base_q    <= base_d;
      cap_idx_q <= cap_idx_d;
      pair_q    <= pair_d;
      total_q   <= total_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: counter times ratio
  // --------------------------------------------------------------------------
  logic          s1_load;
  logic [31:0]   s1_cnt_q;
  logic [63:0]   s1_bc_q;
  logic          s1_cap_q, s1_lev_q, s1_rdt_q, s1_rdl_q;
  logic [AW-1:0] s1_addr_q;
  logic [1:0]    s1_st_q, s1_mode_q;
  logic [31:0]   s1_total_q;

  assign s1_load = in_accept && !seq_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_load) begin
      s1_v_q <= 1'b1;
    end else if (mv1) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_cnt_q   <= snap_cnt;
      s1_bc_q    <= base_corr;
      s1_cap_q   <= do_cap;
      s1_lev_q   <= do_lev;
      s1_rdt_q   <= rd_time;
      s1_rdl_q   <= rd_last;
      s1_addr_q  <= cap_idx_q[AW-1:0];
      s1_st_q    <= st;
      s1_mode_q  <= mode_d;
      s1_total_q <= total_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: frame time assembly, capture and last event writes
  // --------------------------------------------------------------------------
  logic [63:0]   s2_prod_q;
  logic [31:0]   s2_cnt_q;
  logic [63:0]   s2_bc_q;
  logic          s2_cap_q, s2_lev_q, s2_rdt_q, s2_rdl_q;
  logic [AW-1:0] s2_addr_q;
  logic [1:0]    s2_st_q, s2_mode_q;
  logic [31:0]   s2_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (mv1) begin
      s2_v_q <= 1'b1;
    end else if (mv2) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      s2_prod_q  <= 64'(s1_cnt_q) * 64'(ratio_q[31:0]);
      s2_cnt_q   <= s1_cnt_q;
      s2_bc_q    <= s1_bc_q;
      s2_cap_q   <= s1_cap_q;
      s2_lev_q   <= s1_lev_q;
      s2_rdt_q   <= s1_rdt_q;
      s2_rdl_q   <= s1_rdl_q;
      s2_addr_q  <= s1_addr_q;
      s2_st_q    <= s1_st_q;
      s2_mode_q  <= s1_mode_q;
      s2_total_q <= s1_total_q;
    end
  end

  logic [31:0] lod;
  logic [63:0] ftime;
  logic [63:0] s2_tv;

  // scaled counter kept to 32 bits; ratio bit 32 adds the counter itself
  assign lod   = s2_prod_q[63:32] + (ratio_q[32] ? s2_cnt_q : 32'd0);
  assign ftime = s2_bc_q + 64'(lod);
  assign s2_tv = s2_rdt_q ? ftime : (s2_rdl_q ? last_ev_q : 64'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ev_q <= '0;
    end else if (mv2 && s2_lev_q) begin
      last_ev_q <= ftime;
    end
  end

  // capture table
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  ftsu_ram #(
    .WIDTH (64),
    .DEPTH (MAX_STROBES)
  ) u_capture_ram (
    .clk_i   (clk_i),
    .we_i    (mv2 && s2_cap_q),
    .waddr_i (s2_addr_q),
    .wdata_i (ftime),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // pairing unit: interval to ns, error against target, closest pair wins
  // --------------------------------------------------------------------------
  logic [CW-1:0] pair_m1;
  logic [AW-1:0] sq_p_q;
  logic [63:0]   sq_partner_q;
  logic          sq_take_q, sq_last_q, sq_mism_q;
  logic [1:0]    sq_st_q, sq_mode_q;
  logic [31:0]   sq_total_q;
  logic [63:0]   prev_q, cur_q, delta_q;
  logic [63:0]   ll_q, hl_q;
  logic [45:0]   lh_q, hh_q;
  logic [63:0]   ns_q, err_q;
  logic [109:0]  full_prod;

  assign pair_m1   = pair_q - CW'(1);
  assign ram_raddr = (seq_q == ftsu_pkg::SEQ_RD0) ? sq_p_q : pair_m1[AW-1:0];
  assign full_prod = 110'(ll_q) + (110'(lh_q) << 32) + (110'(hl_q) << 32) +
                     (110'(hh_q) << 64);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= ftsu_pkg::SEQ_IDLE;
    end else begin
      unique case (seq_q)
        ftsu_pkg::SEQ_IDLE: begin
          if (seq_go) begin
            seq_q <= take ? ftsu_pkg::SEQ_RD0 : ftsu_pkg::SEQ_UPD;
          end
        end
        ftsu_pkg::SEQ_RD0:  seq_q <= ftsu_pkg::SEQ_RD1;
        ftsu_pkg::SEQ_RD1:  seq_q <= ftsu_pkg::SEQ_MUL;
        ftsu_pkg::SEQ_MUL:  seq_q <= ftsu_pkg::SEQ_SUM;
        ftsu_pkg::SEQ_SUM:  seq_q <= ftsu_pkg::SEQ_ERR;
        ftsu_pkg::SEQ_ERR:  seq_q <= ftsu_pkg::SEQ_UPD;
        ftsu_pkg::SEQ_UPD:  seq_q <= ftsu_pkg::SEQ_DONE;
        ftsu_pkg::SEQ_DONE: begin
          if (out_free) begin
            seq_q <= ftsu_pkg::SEQ_IDLE;
          end
        end
        default: seq_q <= ftsu_pkg::SEQ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_go) begin
      sq_p_q       <= pair_q[AW-1:0];
      sq_partner_q <= partner_time_i;
      sq_take_q    <= take;
      sq_last_q    <= is_last_i;
      sq_mism_q    <= (st == ftsu_pkg::STATUS_MISMATCH);
      sq_st_q      <= st;
      sq_mode_q    <= mode_d;
      sq_total_q   <= total_d;
    end
    if (seq_q == ftsu_pkg::SEQ_RD0) begin
      prev_q <= ram_rdata;
    end
    if (seq_q == ftsu_pkg::SEQ_RD1) begin
      cur_q   <= ram_rdata;
      delta_q <= ram_rdata - prev_q;
    end
    if (seq_q == ftsu_pkg::SEQ_MUL) begin
      ll_q <= 64'(delta_q[31:0])  * 64'(nspr_q[31:0]);
      lh_q <= 46'(delta_q[31:0])  * 46'(nspr_q[45:32]);
      hl_q <= 64'(delta_q[63:32]) * 64'(nspr_q[31:0]);
      hh_q <= 46'(delta_q[63:32]) * 46'(nspr_q[45:32]);
    end
    if (seq_q == ftsu_pkg::SEQ_SUM) begin
      // Q16 product back to ns, saturated to 64 bits
      ns_q <= (full_prod[109:80] != '0) ? '1 : full_prod[79:16];
    end
    if (seq_q == ftsu_pkg::SEQ_ERR) begin
      err_q <= (ns_q > 64'(delay_q)) ? ns_q - 64'(delay_q) : 64'(delay_q) - ns_q;
    end
  end

  // pairing state update: by the pairing unit or cleared by enable
  always_comb begin
    least_d = least_q;
    have_d  = have_q;
    corr_d  = corr_q;
    down_d  = down_q;
    if (seq_q == ftsu_pkg::SEQ_UPD) begin
      // first pair always taken, later ones only when strictly closer
      if (sq_take_q && (!have_q || err_q < least_q)) begin
        least_d = err_q;
        have_d  = 1'b1;
        if (sq_partner_q > cur_q) begin
          corr_d = sq_partner_q - cur_q;
          down_d = 1'b0;
        end else begin
          corr_d = cur_q - sq_partner_q;
          down_d = 1'b1;
        end
      end
      if (sq_last_q || sq_mism_q) begin
        have_d = 1'b0;
      end
    end else if (in_accept && (kind_i == ftsu_pkg::KIND_ENABLE)) begin
      least_d = '0;
      have_d  = 1'b0;
      corr_d  = '0;
      down_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_q <= '0;
      have_q  <= 1'b0;
      corr_q  <= '0;
      down_q  <= 1'b0;
    end else begin
      least_q <= least_d;
      have_q  <= have_d;
      corr_q  <= corr_d;
      down_q  <= down_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic seq_out;

  assign seq_out = (seq_q == ftsu_pkg::SEQ_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (mv2 || seq_out) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      time_value_o       <= s2_tv;
      status_o           <= s2_st_q;
      sync_mode_o        <= s2_mode_q;
      strobes_received_o <= s2_total_q;
    end else if (seq_out) begin
      time_value_o       <= '0;
      status_o           <= sq_st_q;
      sync_mode_o        <= sq_mode_q;
      strobes_received_o <= sq_total_q;
    end
  end

  assign out_valid_o = out_v_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_transfer_while_pairing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) seq_busy |-> !in_accept
  ) else $error("input transfer while pairing unit busy");

  a_pairing_runs_alone : assert property (
    @(posedge clk_i) disable iff (!rst_ni) seq_busy |-> !(s1_v_q || s2_v_q)
  ) else $error("pipeline not empty during pairing");

  a_capture_bounded : assert property (
    @(posedge clk_i) disable iff (!rst_ni) 32'(cap_idx_q) <= 32'(MAX_STROBES)
  ) else $error("capture index beyond table");

  a_enable_syncs : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_accept && kind_i == ftsu_pkg::KIND_ENABLE) |=>
      (mode_q == ftsu_pkg::MODE_SYNCING && cap_idx_q == '0)
  ) else $error("enable did not start syncing");

endmodule
`default_nettype wire
